[rtl/irad_pkg.sv]
// Package for the integer radical block: widths, defaults and the prime table functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package irad_pkg;
  localparam int unsigned NumW        = 31;
  localparam int unsigned PrimeLimDef = 10000;
  localparam int unsigned PrimeW      = 17;
  localparam int unsigned SieveMax    = 65536;

  // Sieve of Eratosthenes up to a limit, used at elaboration only; bit n set means n is prime.
  function automatic logic [SieveMax:0] prime_sieve(input int unsigned lim);
    logic [SieveMax:0] s;
    s = '0;
    for (int unsigned n = 2; n <= lim && n <= SieveMax; n++) begin
      s[n] = 1'b1;
    end
    for (int unsigned p = 2; p * p <= lim; p++) begin
      if (s[p]) begin
        for (int unsigned m = p * p; m <= lim; m += p) begin
          s[m] = 1'b0;
        end
      end
    end
    return s;
  endfunction

  // Number of primes up to a limit, taken from a sieve.
  function automatic int unsigned prime_count(input logic [SieveMax:0] s,
                                              input int unsigned lim);
    int unsigned c;
    c = 0;
    for (int unsigned n = 2; n <= lim; n++) begin
      if (s[n]) c++;
    end
    return c;
  endfunction

  // Prime at a given position of the table, taken from a sieve.
  function automatic int unsigned nth_prime(input logic [SieveMax:0] s,
                                            input int unsigned lim,
                                            input int unsigned idx);
    int unsigned c;
    int unsigned r;
    c = 0;
    r = 2;
    for (int unsigned n = 2; n <= lim; n++) begin
      if (s[n]) begin
        if (c == idx) begin
          r = n;
          break;
        end
        c++;
      end
    end
    return r;
  endfunction
endpackage
`default_nettype wire

[rtl/irad_div.sv]
// Datapath of the integer radical block: prime ROM, restoring divider, accumulator.
// Depends on irad_pkg.
`timescale 1ns / 1ps
`default_nettype none
module irad_div #(
  parameter int unsigned PrimeLimit = irad_pkg::PrimeLimDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      load_i,      // load the number, reset the walk
  input  wire logic [irad_pkg::NumW-1:0] number_i,
  input  wire logic                      div_start_i, // start cof / prime
  input  wire logic                      commit_i,    // cof <= quotient
  input  wire logic                      mul_i,       // acc <= acc * prime
  input  wire logic                      next_i,      // advance to next prime
  output logic                           div_done_o,
  output logic                           rem_zero_o,
  output logic                           cof_one_o,
  output logic                           cof_zero_o,
  output logic                           last_o,
  output logic [irad_pkg::NumW-1:0]      acc_o
);
  import irad_pkg::*;

  localparam logic [SieveMax:0] Sieve = prime_sieve(PrimeLimit);
  localparam int unsigned NPrimes = prime_count(Sieve, PrimeLimit);
  localparam int unsigned IdxW    = (NPrimes > 1) ? $clog2(NPrimes) : 1;
  localparam int unsigned CntW    = $clog2(NumW + 1);

  // Prime table filled at build time.
  logic [PrimeW-1:0] rom [NPrimes];
  for (genvar g = 0; g < NPrimes; g++) begin : g_rom
    localparam int unsigned Val = nth_prime(Sieve, PrimeLimit, g);
    assign rom[g] = PrimeW'(Val);
  end

  logic [IdxW-1:0]   idx_q;
  logic [PrimeW-1:0] prime_q;
  logic [NumW-1:0]   cof_q, quo_q, acc_q;
  logic [PrimeW:0]   rem_q;
  logic [CntW-1:0]   cnt_q;
  logic              busy_q, done_q;

  // Registered ROM read.
  always_ff @(posedge clk_i) begin
    prime_q <= rom[idx_q];
  end

  // Walk index through the table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (load_i) begin
      idx_q <= '0;
    end else if (next_i && !last_o) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  // Restoring division, one quotient bit per cycle.
  logic [PrimeW:0] trial;
  assign trial = {rem_q[PrimeW-1:0], quo_q[NumW-1]};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (div_start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start_i) begin
      quo_q <= cof_q;
      rem_q <= '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, prime_q}) begin
        rem_q <= trial - {1'b0, prime_q};
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  // Cofactor and accumulator; the product stays below 2^31 so truncation is exact.
  logic [NumW-1:0] prod;
  assign prod = NumW'(acc_q * NumW'(prime_q));
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cof_q <= number_i;
      acc_q <= NumW'(1);
    end else begin
      if (commit_i) cof_q <= quo_q;
      if (mul_i)    acc_q <= prod;
    end
  end

  assign div_done_o = done_q;
  assign rem_zero_o = (rem_q == '0);
  assign cof_one_o  = (cof_q == NumW'(1));
  assign cof_zero_o = (cof_q == '0);
  assign last_o     = (idx_q == IdxW'(NPrimes - 1));
  assign acc_o      = acc_q;
endmodule
`default_nettype wire

[rtl/irad_ctrl.sv]
// Controller of the integer radical block: sequences trial divisions and the handshake.
// Imports irad_pkg, though it uses none of its shared widths.
`timescale 1ns / 1ps
`default_nettype none
module irad_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  input  wire logic div_done_i,
  input  wire logic rem_zero_i,
  input  wire logic cof_one_i,
  input  wire logic cof_zero_i,
  input  wire logic last_i,
  output logic      load_o,
  output logic      div_start_o,
  output logic      commit_o,
  output logic      mul_o,
  output logic      next_o,
  output logic      zero_o
);
  import irad_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StRom   = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [2:0] st_q, st_d;
  logic found_q, found_d, zero_q, zero_d, ov_q, ov_d;

  assign in_stall_o  = (st_q != StIdle);
  assign out_valid_o = ov_q;
  assign zero_o      = zero_q;

  // Next state and commands.
  always_comb begin
    st_d = st_q; found_d = found_q; zero_d = zero_q; ov_d = ov_q;
    load_o = 1'b0; div_start_o = 1'b0; commit_o = 1'b0; mul_o = 1'b0; next_o = 1'b0;
    case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          load_o = 1'b1;
          st_d   = StRom;
        end
      end
      StRom: begin
        found_d = 1'b0;
        st_d    = StCheck;
      end
      StCheck: begin
        if (cof_zero_i || cof_one_i) begin
          zero_d = cof_zero_i;
          ov_d   = 1'b1;
          st_d   = StOut;
        end else begin
          div_start_o = 1'b1;
          st_d        = StDiv;
        end
      end
      StDiv: begin
        if (div_done_i) begin
          if (rem_zero_i) begin
            commit_o = 1'b1;
            mul_o    = !found_q;
            found_d  = 1'b1;
            st_d     = StCheck;
          end else if (last_i) begin
            zero_d = 1'b0;
            ov_d   = 1'b1;
            st_d   = StOut;
          end else begin
            next_o = 1'b1;
            st_d   = StRom;
          end
        end
      end
      StOut: begin
        if (!out_stall_i) begin
          ov_d = 1'b0;
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; found_q <= 1'b0; zero_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; found_q <= found_d; zero_q <= zero_d; ov_q <= ov_d;
    end
  end
endmodule
`default_nettype wire

[rtl/integer_radical.sv]
// Integer radical: takes a 31-bit number and returns the product of its distinct prime
// factors up to PrimeLimit, found by trial division against a build-time prime ROM. Each
// trial is a restoring division of one bit per cycle; a prime that does not divide moves
// the walk to the next prime, and one that divides is tried again on the new cofactor. The
// default limit gives a table of 1229 primes; the walk ends early when the cofactor is 1.
// Items are handled one at a time; zero yields 0 and factors above the limit are dropped.
`timescale 1ns / 1ps
`default_nettype none
module integer_radical #(
  parameter int unsigned PrimeLimit = irad_pkg::PrimeLimDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      number_valid_i,
  output logic                           number_stall_o,
  input  wire logic [irad_pkg::NumW-1:0] number_i,
  output logic                           radical_valid_o,
  input  wire logic                      radical_stall_i,
  output logic      [irad_pkg::NumW-1:0] radical_o
);
  import irad_pkg::*;

  logic load, dstart, commit, mul, nxt, zero;
  logic ddone, rz, c1, c0, last;
  logic [NumW-1:0] acc;

  irad_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(number_valid_i), .in_stall_o(number_stall_o),
    .out_valid_o(radical_valid_o), .out_stall_i(radical_stall_i),
    .div_done_i(ddone), .rem_zero_i(rz), .cof_one_i(c1), .cof_zero_i(c0), .last_i(last),
    .load_o(load), .div_start_o(dstart), .commit_o(commit), .mul_o(mul), .next_o(nxt),
    .zero_o(zero)
  );

  irad_div #(.PrimeLimit(PrimeLimit)) u_div (
    .clk_i, .rst_ni, .load_i(load), .number_i, .div_start_i(dstart), .commit_i(commit),
    .mul_i(mul), .next_i(nxt), .div_done_o(ddone), .rem_zero_o(rz), .cof_one_o(c1),
    .cof_zero_o(c0), .last_o(last), .acc_o(acc)
  );

  // Zero input reports zero as its error code.
  assign radical_o = zero ? '0 : acc;
endmodule
`default_nettype wire

[rtl/irad_chk.sv]
// Port checker for the integer radical block, bound to the top level.
// Depends on irad_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module irad_chk (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      number_valid_i,
  input wire logic                      number_stall_o,
  input wire logic                      radical_valid_o,
  input wire logic                      radical_stall_i,
  input wire logic [irad_pkg::NumW-1:0] radical_o
);
  // A waiting result holds its beat.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    radical_valid_o && radical_stall_i |=> radical_valid_o && $stable(radical_o))
    else $error("result changed while stalled");
  // No new item is taken while a result waits.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    radical_valid_o |-> number_stall_o) else $error("input open while result waits");
  // An accepted item never yields a result in the very next cycle.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    number_valid_i && !number_stall_o |=> !radical_valid_o)
    else $error("result too early");
endmodule

bind integer_radical irad_chk u_chk (.*);
`default_nettype wire
